/* design/dre_pkg.sv */
`timescale 1ns / 1ps

package dre_pkg;

    // Field widths of the words on the two channels.
    localparam int CNT_W  = 16;
    localparam int TIME_W = 32;
    localparam int RPM_W  = 32;
    localparam int TPR_W  = 16;

    // Elapsed time is only used when it is positive, so its sign bit is dropped.
    localparam int DT_W = TIME_W - 1;

    // Speed arithmetic: |diff| * 60000 * 2^FRAC_BITS / (ticks_per_rev * dt).
    localparam int FRAC_BITS = 8;
    localparam int MAG_W     = CNT_W;
    localparam int MS_W      = 16;
    localparam logic [MS_W-1:0] MS_PER_MIN = 16'd60000;
    localparam int PROD_W    = MAG_W + MS_W;
    localparam int NUM_W     = PROD_W + FRAC_BITS;
    localparam int DEN_W     = TPR_W + DT_W;
    localparam int REM_W     = DEN_W + 1;
    localparam int STEP_W    = $clog2(NUM_W + 1);

    // Saturation limits of the Q24.8 result.
    localparam logic [RPM_W-1:0] RPM_MAX = {1'b0, {(RPM_W-1){1'b1}}};
    localparam logic [RPM_W-1:0] RPM_MIN = {1'b1, {(RPM_W-1){1'b0}}};

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified word as it travels from the front to the back.
    typedef struct packed {
        logic [CNT_W-1:0] left_raw;
        logic [CNT_W-1:0] right_raw;
        logic [CNT_W-1:0] left_diff;
        logic [CNT_W-1:0] right_diff;
        logic [DT_W-1:0]  dt;
        logic             upd;
    } dre_entry_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_DONE
    } dre_state_t;

    // Applies the sign to a quotient magnitude and saturates to 32 bits.
    function automatic logic [RPM_W-1:0] sat_rpm(input logic neg, input logic [NUM_W-1:0] q);
        logic             over;
        logic [RPM_W-1:0] low;
        over = |q[NUM_W-1:RPM_W-1];
        low  = q[RPM_W-1:0];
        if (!neg)
        begin
            return over ? RPM_MAX : low;
        end
        return over ? RPM_MIN : (~low + RPM_W'(1));
    endfunction

endpackage

/* design/dre_front.sv */
`timescale 1ns / 1ps

module dre_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [dre_pkg::TIME_W-1:0]        time_ms,
    input  logic signed [dre_pkg::CNT_W-1:0]  left_count,
    input  logic signed [dre_pkg::CNT_W-1:0]  right_count,
    input  logic                              q_full,
    output logic                              q_push,
    output dre_pkg::dre_entry_t               q_wdata
);
    import dre_pkg::*;

    logic [CNT_W-1:0]  prev_left_reg;
    logic [CNT_W-1:0]  prev_right_reg;
    logic [TIME_W-1:0] prev_time_reg;
    logic [TIME_W-1:0] dt_full;

    // A word is taken whenever the queue has room.
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    // Elapsed time counts only when it is nonzero and below half the wrap range.
    assign dt_full = time_ms - prev_time_reg;

    // The 16-bit wrap of the count difference is the fold into the signed range.
    always_comb
    begin
        q_wdata.left_raw   = left_count;
        q_wdata.right_raw  = right_count;
        q_wdata.left_diff  = left_count - prev_left_reg;
        q_wdata.right_diff = right_count - prev_right_reg;
        q_wdata.dt         = dt_full[DT_W-1:0];
        q_wdata.upd        = (dt_full != '0) && !dt_full[TIME_W-1];
    end

    // The last counts and time follow every accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            prev_time_reg  <= '0;
        end
        else if (q_push)
        begin
            prev_left_reg  <= left_count;
            prev_right_reg <= right_count;
            prev_time_reg  <= time_ms;
        end
    end

endmodule

/* design/dre_queue.sv */
`timescale 1ns / 1ps

module dre_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dre_pkg::dre_entry_t  wdata,
    input  logic                 pop,
    output dre_pkg::dre_entry_t  rdata,
    output logic                 full,
    output logic                 empty
);
    import dre_pkg::*;

    dre_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = slot_reg[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

/* design/dre_div.sv */
`timescale 1ns / 1ps

module dre_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [dre_pkg::NUM_W-1:0]  num,
    input  logic [dre_pkg::DEN_W-1:0]  den,
    output logic                       busy,
    output logic [dre_pkg::NUM_W-1:0]  quot
);
    import dre_pkg::*;

    logic [REM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  qn_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W:0]    trial;
    logic              ge;

    assign busy = busy_reg;
    assign quot = qn_reg;

    // One restoring step: shift in the next numerator bit and try the subtraction.
    assign rem_sh = {rem_reg[REM_W-2:0], qn_reg[NUM_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, den_reg};
    assign ge     = !trial[REM_W];

    // Operands and partial results; the numerator register collects the quotient.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            qn_reg  <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? trial[REM_W-1:0] : rem_sh;
            qn_reg  <= {qn_reg[NUM_W-2:0], ge};
        end
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

endmodule

/* design/dre_back.sv */
`timescale 1ns / 1ps

module dre_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [dre_pkg::TPR_W-1:0]         tpr,
    input  logic                              q_empty,
    input  dre_pkg::dre_entry_t               q_rdata,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [dre_pkg::CNT_W-1:0]  left_raw,
    output logic signed [dre_pkg::CNT_W-1:0]  right_raw,
    output logic signed [dre_pkg::RPM_W-1:0]  left_rpm,
    output logic signed [dre_pkg::RPM_W-1:0]  right_rpm,
    output logic                              rpm_updated
);
    import dre_pkg::*;

    dre_state_t        state_reg;
    dre_state_t        state_next;
    dre_entry_t        ent_reg;
    logic              div_start;
    logic              out_load;
    logic              busy_l;
    logic              busy_r;
    logic [NUM_W-1:0]  quot_l;
    logic [NUM_W-1:0]  quot_r;
    logic [MAG_W-1:0]  mag_l;
    logic [MAG_W-1:0]  mag_r;
    logic [PROD_W-1:0] prod_l;
    logic [PROD_W-1:0] prod_r;
    logic [NUM_W-1:0]  num_l;
    logic [NUM_W-1:0]  num_r;
    logic [TPR_W-1:0]  tpr_eff;
    logic [DEN_W-1:0]  den;
    logic [RPM_W-1:0]  speed_l;
    logic [RPM_W-1:0]  speed_r;
    logic [RPM_W-1:0]  held_l_reg;
    logic [RPM_W-1:0]  held_r_reg;
    logic              out_valid_reg;
    logic [CNT_W-1:0]  left_raw_reg;
    logic [CNT_W-1:0]  right_raw_reg;
    logic [RPM_W-1:0]  left_rpm_reg;
    logic [RPM_W-1:0]  right_rpm_reg;
    logic              rpm_updated_reg;

    // Magnitudes of the folded differences; the most negative value fits unsigned.
    assign mag_l = ent_reg.left_diff[CNT_W-1] ? (~ent_reg.left_diff + MAG_W'(1))
                                              : ent_reg.left_diff;
    assign mag_r = ent_reg.right_diff[CNT_W-1] ? (~ent_reg.right_diff + MAG_W'(1))
                                               : ent_reg.right_diff;

    // Numerators and the shared denominator; the dividers register them on start.
    assign prod_l  = PROD_W'(mag_l) * PROD_W'(MS_PER_MIN);
    assign prod_r  = PROD_W'(mag_r) * PROD_W'(MS_PER_MIN);
    assign num_l   = NUM_W'(prod_l) << FRAC_BITS;
    assign num_r   = NUM_W'(prod_r) << FRAC_BITS;
    assign tpr_eff = (tpr == '0) ? TPR_W'(1) : tpr;
    assign den     = DEN_W'(tpr_eff) * DEN_W'(ent_reg.dt);

    dre_div u_div_left (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_l),
        .den   (den),
        .busy  (busy_l),
        .quot  (quot_l)
    );

    dre_div u_div_right (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_r),
        .den   (den),
        .busy  (busy_r),
        .quot  (quot_r)
    );

    // Signed and saturated speeds from the quotients.
    assign speed_l = sat_rpm(ent_reg.left_diff[CNT_W-1], quot_l);
    assign speed_r = sat_rpm(ent_reg.right_diff[CNT_W-1], quot_r);

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and control strobes.
    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = q_rdata.upd ? BK_MUL : BK_DONE;
                end
            end
            BK_MUL:
            begin
                div_start  = 1'b1;
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                if (!busy_l && !busy_r)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Word being worked on.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            ent_reg <= q_rdata;
        end
    end

    // Held speeds change only when time has passed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_l_reg <= '0;
            held_r_reg <= '0;
        end
        else if (out_load && ent_reg.upd)
        begin
            held_l_reg <= speed_l;
            held_r_reg <= speed_r;
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            left_raw_reg    <= ent_reg.left_raw;
            right_raw_reg   <= ent_reg.right_raw;
            left_rpm_reg    <= ent_reg.upd ? speed_l : held_l_reg;
            right_rpm_reg   <= ent_reg.upd ? speed_r : held_r_reg;
            rpm_updated_reg <= ent_reg.upd;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_raw    = left_raw_reg;
    assign right_raw   = right_raw_reg;
    assign left_rpm    = left_rpm_reg;
    assign right_rpm   = right_rpm_reg;
    assign rpm_updated = rpm_updated_reg;

endmodule

/* design/dual_encoder_rpm_meter_unit.sv */
// Dual wheel encoder speed meter. Each input word carries a millisecond timestamp and the
// left and right 16-bit encoder counts; each output word returns both counts unchanged and
// both wheel speeds in signed Q24.8 RPM, with rpm_updated set when time has passed since
// the previous word (otherwise the last speeds are repeated). A word whose time has moved
// on leaves the queue, has its multiplies formed, runs 40 steps of the bit-serial
// dividers (one per wheel, running side by side), lets the sequencer see them finish
// and then reaches the output register. A word with no elapsed time goes from the
// queue straight to the output register. The front takes words while the two-entry queue
// has room, so up to two words can be waiting behind the one in progress. ticks_per_rev
// resets to 1 and a value of 0 is treated as 1; write it only while no word is in flight.
`timescale 1ns / 1ps

module dual_encoder_rpm_meter_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [dre_pkg::TPR_W-1:0]         cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [dre_pkg::TIME_W-1:0]        time_ms,
    input  logic signed [dre_pkg::CNT_W-1:0]  left_count,
    input  logic signed [dre_pkg::CNT_W-1:0]  right_count,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [dre_pkg::CNT_W-1:0]  left_raw,
    output logic signed [dre_pkg::CNT_W-1:0]  right_raw,
    output logic signed [dre_pkg::RPM_W-1:0]  left_rpm,
    output logic signed [dre_pkg::RPM_W-1:0]  right_rpm,
    output logic                              rpm_updated
);
    import dre_pkg::*;

    logic [TPR_W-1:0] tpr_reg;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    dre_entry_t       q_wdata;
    dre_entry_t       q_rdata;

    // Ticks per revolution register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpr_reg <= TPR_W'(1);
        end
        else if (cfg_wr_en)
        begin
            tpr_reg <= cfg_wr_data;
        end
    end

    dre_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .time_ms     (time_ms),
        .left_count  (left_count),
        .right_count (right_count),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_wdata     (q_wdata)
    );

    dre_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    dre_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .tpr         (tpr_reg),
        .q_empty     (q_empty),
        .q_rdata     (q_rdata),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .left_raw    (left_raw),
        .right_raw   (right_raw),
        .left_rpm    (left_rpm),
        .right_rpm   (right_rpm),
        .rpm_updated (rpm_updated)
    );

    // The queue can never report full and empty at once.
    assert property (@(posedge clk) disable iff (!rst_n) !(q_full && q_empty))
        else $error("queue reports full and empty together");

    // The back end only takes a word that is really there.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("back end popped an empty queue");

    // An accepted input word always finds room in the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (in_valid && !in_stall) |-> (q_push && !q_full))
        else $error("input word accepted without queue room");

endmodule
